// ----- hw/rtl/bfdh_pkg.sv -----
// Shared types, constants and helper functions for the double-hash Bloom filter.
package bfdh_pkg;

    // Command codes carried with each item.
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_INSERT    = 2'd0;
    localparam cmd_t CMD_QUERY     = 2'd1;
    localparam cmd_t CMD_FALSE_POS = 2'd2;

    // Hash seeds and counter width.
    localparam logic [63:0] DJB_INIT = 64'd5381;
    localparam logic [63:0] FNV_INIT = 64'hCBF29CE484222325;
    localparam int          CNT_W    = 32;

    typedef logic [CNT_W-1:0] cnt_t;

    // Multiply by the FNV prime 2^40 + 0x1B3, kept to 64 bits, as shifts and adds.
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    // Saturating increment of a 32-bit counter.
    function automatic cnt_t sat_inc(input cnt_t c);
        sat_inc = (c == '1) ? c : c + cnt_t'(1);
    endfunction

endpackage

// ----- hw/rtl/bloom_filter_double_hash.sv -----
// Bloom filter with djb2/FNV-1a double hashing over a byte-serial key stream.
//
// Keys arrive one byte per item; each insert or query byte with has_byte set is hashed
// as it is accepted. The item marked last starts the probe sequence for an insert or a
// query: every probe reduces the 64-bit probe value modulo num_bits through a bit-serial
// remainder unit and then does a read-modify-write of one byte of the bit store; a query
// stops at its first clear bit. A false-positive report skips the probes. The bit store
// is an on-chip RAM of MAX_BITS/8 bytes that is swept to zero after reset, one byte per
// cycle; no item is accepted during that sweep, while configuration writes are taken at
// any time. Results wait in an output register, and each counter saturates at 2^32-1.
module bloom_filter_double_hash #(
    parameter int MAX_BITS   = 65536,
    parameter int MAX_HASHES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    // Configuration write port.
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [16:0]      cfg_data,
    // Input channel.
    input  logic             in_valid,
    output logic             in_ready,
    input  bfdh_pkg::cmd_t   command,
    input  logic [7:0]       key_byte,
    input  logic             has_byte,
    input  logic             last,
    // Output channel.
    output logic             out_valid,
    input  logic             out_ready,
    output logic             maybe_present,
    output bfdh_pkg::cnt_t   inserted_count,
    output bfdh_pkg::cnt_t   query_count,
    output bfdh_pkg::cnt_t   rejected_count,
    output bfdh_pkg::cnt_t   false_positive_count
);
    import bfdh_pkg::*;

    localparam int MW    = $clog2(MAX_BITS + 1);
    localparam int CW    = (MW > 17) ? MW : 17;
    localparam int KW    = $clog2(MAX_HASHES + 1);
    localparam int KC    = (KW > 5) ? KW : 5;
    localparam int DEPTH = (MAX_BITS + 7) / 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_PUSH
    } state_t;

    state_t          state_reg;
    logic [16:0]     num_bits_reg;
    logic [4:0]      num_hashes_reg;
    logic [63:0]     djb_reg;
    logic [63:0]     fnv_reg;
    logic [63:0]     acc_reg;
    logic [63:0]     step_reg;
    logic [MW-1:0]   rem_reg;
    logic [5:0]      bit_cnt_reg;
    logic [KW-1:0]   probe_cnt_reg;
    cmd_t            cmd_reg;
    logic            present_reg;
    logic [AW-1:0]   clr_reg;
    cnt_t            ins_reg;
    cnt_t            qry_reg;
    cnt_t            rej_reg;
    cnt_t            fp_reg;
    logic            out_valid_reg;
    logic            out_present_reg;
    cnt_t            out_ins_reg;
    cnt_t            out_qry_reg;
    cnt_t            out_rej_reg;
    cnt_t            out_fp_reg;

    logic [CW-1:0]   m_ext;
    logic [CW-1:0]   m_clamp;
    logic [MW-1:0]   m_eff;
    logic [KC-1:0]   k_ext;
    logic [KC-1:0]   k_clamp;
    logic [KW-1:0]   k_eff;
    logic            hash_en;
    logic [63:0]     djb_next;
    logic [63:0]     fnv_next;
    logic [MW:0]     rem_sh;
    logic [MW-1:0]   rem_next;
    logic            probe_last;
    logic [AW-1:0]   byte_addr;
    logic [2:0]      bit_sel;
    logic            bit_hit;
    logic            out_free;
    cnt_t            ins_next;
    cnt_t            qry_next;
    cnt_t            rej_next;
    cnt_t            fp_next;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;

    // Effective filter size and probe count, clamped to their legal ranges.
    always_comb
    begin
        m_ext = CW'(num_bits_reg);
        if (m_ext < CW'(8))
            m_clamp = CW'(8);
        else if (m_ext > CW'(MAX_BITS))
            m_clamp = CW'(MAX_BITS);
        else
            m_clamp = m_ext;
        m_eff = MW'(m_clamp);

        k_ext = KC'(num_hashes_reg);
        if (k_ext < KC'(1))
            k_clamp = KC'(1);
        else if (k_ext > KC'(MAX_HASHES))
            k_clamp = KC'(MAX_HASHES);
        else
            k_clamp = k_ext;
        k_eff = KW'(k_clamp);
    end

    // Byte hashing for insert and query keys.
    assign hash_en  = has_byte && ((command == CMD_INSERT) || (command == CMD_QUERY));
    assign djb_next = hash_en ? ((djb_reg << 5) + djb_reg + 64'(key_byte)) : djb_reg;
    assign fnv_next = hash_en ? fnv_mul(fnv_reg ^ 64'(key_byte)) : fnv_reg;

    // One step of the restoring remainder unit, most significant bit first.
    assign rem_sh   = {rem_reg, acc_reg[~bit_cnt_reg]};
    assign rem_next = (rem_sh >= {1'b0, m_eff}) ? MW'(rem_sh - {1'b0, m_eff}) : MW'(rem_sh);

    assign probe_last = (probe_cnt_reg == (k_eff - KW'(1)));
    assign byte_addr  = AW'(rem_reg >> 3);
    assign bit_sel    = rem_reg[2:0];
    assign bit_hit    = ram_rdata[bit_sel];
    assign out_free   = !out_valid_reg || out_ready;

    // Counter values after the pending command.
    always_comb
    begin
        ins_next = ins_reg;
        qry_next = qry_reg;
        rej_next = rej_reg;
        fp_next  = fp_reg;
        case (cmd_reg)
            CMD_INSERT:
            begin
                ins_next = sat_inc(ins_reg);
            end
            CMD_QUERY:
            begin
                qry_next = sat_inc(qry_reg);
                if (!present_reg)
                    rej_next = sat_inc(rej_reg);
            end
            CMD_FALSE_POS:
            begin
                fp_next = sat_inc(fp_reg);
            end
            default:
            begin
                ins_next = ins_reg;
            end
        endcase
    end

    // Bit store port control: clearing sweep or setting a probe bit.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = byte_addr;
        ram_wdata = ram_rdata | (8'd1 << bit_sel);
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = 8'd0;
        end
        else if ((state_reg == S_CHK) && (cmd_reg == CMD_INSERT))
        begin
            ram_we = 1'b1;
        end
    end

    bfdh_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (byte_addr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bits_reg   <= 17'd65536;
            num_hashes_reg <= 5'd7;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
                num_bits_reg <= cfg_data;
            else
                num_hashes_reg <= cfg_data[4:0];
        end
    end

    // Sequencer with hash state, counters and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            djb_reg         <= DJB_INIT;
            fnv_reg         <= FNV_INIT;
            acc_reg         <= '0;
            step_reg        <= '0;
            rem_reg         <= '0;
            bit_cnt_reg     <= '0;
            probe_cnt_reg   <= '0;
            cmd_reg         <= CMD_INSERT;
            present_reg     <= 1'b0;
            ins_reg         <= '0;
            qry_reg         <= '0;
            rej_reg         <= '0;
            fp_reg          <= '0;
            out_valid_reg   <= 1'b0;
            out_present_reg <= 1'b0;
            out_ins_reg     <= '0;
            out_qry_reg     <= '0;
            out_rej_reg     <= '0;
            out_fp_reg      <= '0;
        end
        else
        begin
            // A taken result is dropped unless a new one replaces it in the same cycle.
            if (out_valid_reg && out_ready && (state_reg != S_PUSH))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (!last)
                        begin
                            djb_reg <= djb_next;
                            fnv_reg <= fnv_next;
                        end
                        else
                        begin
                            djb_reg       <= DJB_INIT;
                            fnv_reg       <= FNV_INIT;
                            cmd_reg       <= command;
                            acc_reg       <= djb_next;
                            step_reg      <= fnv_next | 64'd1;
                            rem_reg       <= '0;
                            bit_cnt_reg   <= '0;
                            probe_cnt_reg <= '0;
                            present_reg   <= (command == CMD_QUERY);
                            if ((command == CMD_INSERT) || (command == CMD_QUERY))
                                state_reg <= S_DIV;
                            else if (command == CMD_FALSE_POS)
                                state_reg <= S_PUSH;
                        end
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= rem_next;
                    bit_cnt_reg <= bit_cnt_reg + 6'd1;
                    if (bit_cnt_reg == 6'd63)
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if ((cmd_reg == CMD_QUERY) && !bit_hit)
                    begin
                        present_reg <= 1'b0;
                        state_reg   <= S_PUSH;
                    end
                    else if (probe_last)
                    begin
                        state_reg <= S_PUSH;
                    end
                    else
                    begin
                        probe_cnt_reg <= probe_cnt_reg + KW'(1);
                        acc_reg       <= acc_reg + step_reg;
                        rem_reg       <= '0;
                        bit_cnt_reg   <= '0;
                        state_reg     <= S_DIV;
                    end
                end
                S_PUSH:
                begin
                    if (out_free)
                    begin
                        ins_reg         <= ins_next;
                        qry_reg         <= qry_next;
                        rej_reg         <= rej_next;
                        fp_reg          <= fp_next;
                        out_valid_reg   <= 1'b1;
                        out_present_reg <= present_reg;
                        out_ins_reg     <= ins_next;
                        out_qry_reg     <= qry_next;
                        out_rej_reg     <= rej_next;
                        out_fp_reg      <= fp_next;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid            = out_valid_reg;
    assign maybe_present        = out_present_reg;
    assign inserted_count       = out_ins_reg;
    assign query_count          = out_qry_reg;
    assign rejected_count       = out_rej_reg;
    assign false_positive_count = out_fp_reg;

`ifndef NO_ASSERTIONS
    // The remainder unit always leaves a bit index inside the filter.
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (rem_reg < m_eff))
        else $error("probe index outside the filter");

    // Probing never runs past the configured probe count.
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (probe_cnt_reg < k_eff))
        else $error("probe counter past num_hashes");

    // Both hashes return to their seeds after the last item of a key.
    a_hash_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> ((djb_reg == DJB_INIT) && (fnv_reg == FNV_INIT)))
        else $error("hashes not reseeded after last item");

    // Rejections are a subset of queries.
    a_rej_le_qry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_rej_reg <= out_qry_reg))
        else $error("rejected count above query count");
`endif

endmodule

// ----- hw/rtl/bfdh_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module bfdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- bench/tb_bloom_filter_double_hash.sv -----
// Self-checking testbench for the double-hash Bloom filter: queued stimulus, clocked checker.
`timescale 1ns / 1ps

module tb_bloom_filter_double_hash;
    import bfdh_pkg::*;

    localparam cmd_t        CMD_UNUSED  = 2'd3;
    localparam logic        REG_BITS    = 1'b0;
    localparam logic        REG_HASHES  = 1'b1;
    localparam int          FILTER_MAX  = 65536;
    localparam int          HASH_MAX    = 16;
    localparam logic [63:0] FNV_PRIME   = 64'd1099511628211;
    localparam int          SETTLE      = 1200;
    localparam int          LONG_HOLD   = 3000;
    localparam longint      CYCLE_LIMIT = 3000000;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       has;
        logic       fin;
    } key_item_t;

    typedef struct packed {
        logic present;
        cnt_t ins;
        cnt_t qry;
        cnt_t rej;
        cnt_t fps;
    } filter_status_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [16:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    cmd_t       command = CMD_INSERT;
    logic [7:0] key_byte = '0;
    logic       has_byte = 1'b0;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       maybe_present;
    cnt_t       inserted_count;
    cnt_t       query_count;
    cnt_t       rejected_count;
    cnt_t       false_positive_count;

    bloom_filter_double_hash i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .key_byte(key_byte), .has_byte(has_byte), .last(last),
        .out_valid(out_valid), .out_ready(out_ready),
        .maybe_present(maybe_present), .inserted_count(inserted_count),
        .query_count(query_count), .rejected_count(rejected_count),
        .false_positive_count(false_positive_count)
    );

    // Shadow copy of the filter state.
    logic [16:0] shadow_bits_reg;
    logic [4:0]  shadow_hashes_reg;
    logic [63:0] djb_acc;
    logic [63:0] fnv_acc;
    logic        filter_bits [0:FILTER_MAX-1];
    cnt_t        ins_seen, qry_seen, rej_seen, fps_seen;

    key_item_t      pending_items[$];
    filter_status_t expected_status[$];
    key_item_t      cur_item;
    int             error_count = 0;
    longint         cycle_count = 0;
    int             burst_left = 0;
    int             gap_left = 0;
    logic           hold_req = 1'b0;
    int             hold_cnt = 0;
    int             stall_mode = 0;
    int             stall_run = 0;

    // Pool of inserted keys, so that queries hit as well as miss.
    logic [7:0] key_pool [0:63][0:11];
    int         key_pool_len [0:63];
    int         key_pool_n = 0;

    always #10 clk = ~clk;

    function automatic cnt_t count_up(input cnt_t c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    // Runs the probe sequence; sets bits on insert, returns the query answer.
    function automatic logic probe_filter(input logic do_insert);
        logic [63:0] m, k, h2, p, i;
        m = {47'd0, shadow_bits_reg};
        if (m < 8) m = 8;
        if (m > FILTER_MAX) m = FILTER_MAX;
        k = {59'd0, shadow_hashes_reg};
        if (k < 1) k = 1;
        if (k > HASH_MAX) k = HASH_MAX;
        h2 = fnv_acc | 64'd1;
        for (i = 0; i < k; i++) begin
            p = (djb_acc + i * h2) % m;
            if (do_insert) filter_bits[p] = 1'b1;
            else if (!filter_bits[p]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Folds one accepted item into the shadow state and queues its status, if any.
    task automatic absorb_item(input key_item_t it);
        filter_status_t st;
        st.present = 1'b0;
        if (it.has && (it.cmd == CMD_INSERT || it.cmd == CMD_QUERY)) begin
            djb_acc = (djb_acc << 5) + djb_acc + {56'd0, it.data};
            fnv_acc = (fnv_acc ^ {56'd0, it.data}) * FNV_PRIME;
        end
        if (it.fin) begin
            if (it.cmd == CMD_INSERT) begin
                void'(probe_filter(1'b1));
                ins_seen = count_up(ins_seen);
            end else if (it.cmd == CMD_QUERY) begin
                qry_seen = count_up(qry_seen);
                st.present = probe_filter(1'b0);
                if (!st.present) rej_seen = count_up(rej_seen);
            end else if (it.cmd == CMD_FALSE_POS) begin
                fps_seen = count_up(fps_seen);
            end
            djb_acc = DJB_INIT;
            fnv_acc = FNV_INIT;
            if (it.cmd != CMD_UNUSED) begin
                st.ins = ins_seen;
                st.qry = qry_seen;
                st.rej = rej_seen;
                st.fps = fps_seen;
                expected_status.push_back(st);
            end
        end
    endtask

    task automatic push_item(input cmd_t c, input logic [7:0] d, input logic h,
                             input logic f);
        key_item_t it;
        it.cmd = c;
        it.data = d;
        it.has = h;
        it.fin = f;
        pending_items.push_back(it);
    endtask

    // Pushes a key of random bytes; inserted keys go to the pool.
    task automatic push_random_key(input cmd_t c, input int len);
        int slot;
        slot = key_pool_n % 64;
        for (int j = 0; j < len; j++) begin
            key_pool[slot][j] = 8'($urandom);
            push_item(c, key_pool[slot][j], 1'b1, j == len - 1);
        end
        key_pool_len[slot] = len;
        if (c == CMD_INSERT) key_pool_n++;
    endtask

    // Replays a pooled key under the given command.
    task automatic push_pool_key(input cmd_t c);
        int slot;
        if (key_pool_n == 0) begin
            push_random_key(c, 2);
        end else begin
            slot = $urandom_range(0, (key_pool_n > 64 ? 64 : key_pool_n) - 1);
            for (int j = 0; j < key_pool_len[slot]; j++)
                push_item(c, key_pool[slot][j], 1'b1, j == key_pool_len[slot] - 1);
        end
    endtask

    function automatic int pick_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    endfunction

    // Random traffic: mostly whole keys, some odd commands and noise.
    task automatic push_random_traffic(input int n);
        int start, r, len;
        start = pending_items.size();
        while (pending_items.size() - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 38) begin
                push_random_key(CMD_INSERT, pick_len());
            end else if (r < 56) begin
                push_pool_key(CMD_QUERY);
            end else if (r < 72) begin
                push_random_key(CMD_QUERY, pick_len());
            end else if (r < 78) begin
                len = $urandom_range(0, 2);
                for (int j = 0; j < len; j++) push_item(CMD_FALSE_POS, 8'($urandom), 1'b1, 0);
                push_item(CMD_FALSE_POS, 8'($urandom), 1'($urandom), 1'b1);
            end else if (r < 83) begin
                len = $urandom_range(0, 2);
                for (int j = 0; j < len; j++) push_item(CMD_UNUSED, 8'($urandom), 1'b1, 0);
                push_item(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'b1);
            end else if (r < 90) begin
                len = $urandom_range(1, 5);
                for (int j = 0; j < len; j++)
                    push_item(cmd_t'($urandom_range(0, 3)), 8'($urandom), 1'b1, 0);
                push_item(cmd_t'($urandom_range(0, 2)), 8'($urandom), 1'($urandom), 1'b1);
            end else if (r < 94) begin
                push_item($urandom_range(0, 1) ? CMD_QUERY : CMD_INSERT, 8'($urandom),
                          1'b0, 1'b1);
            end else begin
                // Noise: bytes without has_byte inside a key.
                push_item(cmd_t'($urandom_range(0, 1)), 8'($urandom), 1'b0, 0);
                push_item(CMD_INSERT, 8'($urandom), 1'b1, 0);
                push_item(CMD_QUERY, 8'($urandom), 1'b0, 1'b1);
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (!(pending_items.size() == 0 && !in_valid && expected_status.size() == 0));
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_BITS) shadow_bits_reg = value;
        else shadow_hashes_reg = value[4:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One phase: new setting, traffic, a pause until drained, more traffic.
    task automatic run_phase(input logic [16:0] nb, input logic [16:0] nh, input int n,
                             input logic long_stall);
        wait_idle();
        write_reg(REG_BITS, nb);
        write_reg(REG_HASHES, nh);
        if (long_stall) hold_req = 1'b1;
        push_random_traffic(n / 2);
        wait_idle();
        push_random_traffic(n - n / 2);
    endtask

    // Driver: bursts of items separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready) absorb_item(cur_item);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    command <= cur_item.cmd;
                    key_byte <= cur_item.data;
                    has_byte <= cur_item.has;
                    last <= cur_item.fin;
                    in_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: free-running, random and heavy stall stretches, plus a long hold in each of two phases.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (stall_run == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    stall_run = $urandom_range(10, 300);
                end
                stall_run--;
                case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Checker: each accepted result against the oldest expected status.
    always @(posedge clk)
    begin
        filter_status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got present %0b ins %0d",
                         $time, maybe_present, inserted_count);
                error_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (maybe_present !== want.present)
                begin
                    $display("%0t: maybe_present expected %0b actual %0b",
                             $time, want.present, maybe_present);
                    error_count++;
                end
                if (inserted_count !== want.ins)
                begin
                    $display("%0t: inserted_count expected %0d actual %0d",
                             $time, want.ins, inserted_count);
                    error_count++;
                end
                if (query_count !== want.qry)
                begin
                    $display("%0t: query_count expected %0d actual %0d",
                             $time, want.qry, query_count);
                    error_count++;
                end
                if (rejected_count !== want.rej)
                begin
                    $display("%0t: rejected_count expected %0d actual %0d",
                             $time, want.rej, rejected_count);
                    error_count++;
                end
                if (false_positive_count !== want.fps)
                begin
                    $display("%0t: false_positive_count expected %0d actual %0d",
                             $time, want.fps, false_positive_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin
        shadow_bits_reg = 17'd65536;
        shadow_hashes_reg = 5'd7;
        djb_acc = DJB_INIT;
        fnv_acc = FNV_INIT;
        for (int j = 0; j < FILTER_MAX; j++) filter_bits[j] = 1'b0;
        ins_seen = '0;
        qry_seen = '0;
        rej_seen = '0;
        fps_seen = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty keys, byte extremes, hit and miss, odd commands.
        push_item(CMD_QUERY, 8'h00, 1'b0, 1'b1);
        push_item(CMD_INSERT, 8'hFF, 1'b0, 1'b1);
        push_item(CMD_QUERY, 8'h5A, 1'b0, 1'b1);
        push_item(CMD_INSERT, 8'h00, 1'b1, 1'b0);
        push_item(CMD_INSERT, 8'hFF, 1'b1, 1'b1);
        push_item(CMD_QUERY, 8'h00, 1'b1, 1'b0);
        push_item(CMD_QUERY, 8'hFF, 1'b1, 1'b1);
        push_item(CMD_QUERY, 8'hFF, 1'b1, 1'b0);
        push_item(CMD_QUERY, 8'h00, 1'b1, 1'b1);
        push_item(CMD_INSERT, 8'h00, 1'b1, 1'b0);
        push_item(CMD_INSERT, 8'hFF, 1'b1, 1'b1);
        push_item(CMD_FALSE_POS, 8'hA5, 1'b1, 1'b0);
        push_item(CMD_FALSE_POS, 8'h3C, 1'b1, 1'b1);
        push_item(CMD_UNUSED, 8'h77, 1'b1, 1'b0);
        push_item(CMD_UNUSED, 8'h11, 1'b1, 1'b1);
        push_item(CMD_INSERT, 8'h41, 1'b1, 1'b0);
        push_item(CMD_QUERY, 8'h42, 1'b1, 1'b0);
        push_item(CMD_UNUSED, 8'h43, 1'b1, 1'b0);
        push_item(CMD_FALSE_POS, 8'h44, 1'b1, 1'b0);
        push_item(CMD_QUERY, 8'h45, 1'b1, 1'b1);
        push_item(CMD_QUERY, 8'h41, 1'b1, 1'b0);
        push_item(CMD_INSERT, 8'h42, 1'b1, 1'b0);
        push_item(CMD_INSERT, 8'h45, 1'b1, 1'b1);
        push_item(CMD_FALSE_POS, 8'h00, 1'b0, 1'b1);

        run_phase(17'd65536, 17'd7, 170, 1'b1);
        run_phase(17'd8, 17'd1, 170, 1'b0);
        run_phase(17'd65536, 17'd16, 170, 1'b0);
        run_phase(17'd0, 17'd0, 170, 1'b1);
        run_phase(17'h1FFFF, 17'd31, 170, 1'b0);
        run_phase(17'd1000, 17'd3, 170, 1'b0);

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
